// ----- rtl/core/mma_pkg.sv -----
`default_nettype none
package mma_pkg;

	localparam int NUM_CHANNELS  = 8;
	localparam int MAX_WINDOW    = 64;
	localparam int SAMPLE_BITS   = 16;
	localparam int CHAN_BITS     = $clog2(NUM_CHANNELS);
	localparam int POS_BITS      = $clog2(MAX_WINDOW);
	localparam int COUNT_BITS    = POS_BITS + 1;
	localparam int REG_BITS      = 7;
	localparam int SUM_BITS      = SAMPLE_BITS + POS_BITS + 1;
	localparam int ADDR_BITS     = CHAN_BITS + POS_BITS;
	localparam int PADDR_BITS    = CHAN_BITS + 2;
	localparam int PDATA_BITS    = 32;

	// radix-16 restoring divider: four quotient bits per step
	localparam int DIV_BITS_STEP = 4;
	localparam int DIV_STEPS     = 6;
	localparam int DIVIDEND_BITS = DIV_BITS_STEP * DIV_STEPS;
	localparam int REM_BITS      = COUNT_BITS + 1;
	localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [CHAN_BITS-1:0]          channel;
		logic signed [SAMPLE_BITS-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0]          out_channel;
		logic signed [SAMPLE_BITS-1:0] average;
		logic [COUNT_BITS-1:0]         fill_count;
	} out_item_t;

	typedef struct packed {
		logic take_item;
		logic read_slot;
		logic update;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_full;
	} status_t;

endpackage
`default_nettype wire

// ----- rtl/core/mma_ctrl.sv -----
`default_nettype none
module mma_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire mma_pkg::status_t status,
	output mma_pkg::cmd_t        cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.take_item = 1'b1;
					state_d       = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read_slot = 1'b1;
				state_d       = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				// hold here while the previous result has not been taken
				if (!status.out_full) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/mma_datapath.sv -----
`default_nettype none
module mma_datapath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire mma_pkg::cmd_t                        cmd,
	output mma_pkg::status_t                          status,
	input  wire mma_pkg::in_item_t                    req_item,
	output logic                                      rsp_valid,
	input  wire logic                                 rsp_ready,
	output mma_pkg::out_item_t                        rsp_item,
	input  wire logic                                 cfg_write,
	input  wire logic [mma_pkg::CHAN_BITS-1:0]        cfg_index,
	input  wire logic [mma_pkg::REG_BITS-1:0]         cfg_value,
	output logic [mma_pkg::REG_BITS-1:0]              cfg_rdata
);

	localparam int NCH = mma_pkg::NUM_CHANNELS;
	localparam int SB  = mma_pkg::SAMPLE_BITS;
	localparam int SUB = mma_pkg::SUM_BITS;
	localparam int CB  = mma_pkg::COUNT_BITS;
	localparam int PB  = mma_pkg::POS_BITS;
	localparam int DB  = mma_pkg::DIVIDEND_BITS;
	localparam int RB  = mma_pkg::REM_BITS;

	// per-channel state
	logic [mma_pkg::REG_BITS-1:0] win_reg_q [NCH];
	logic signed [SUB-1:0]        sum_q     [NCH];
	logic [PB-1:0]                wpos_q    [NCH];
	logic [CB-1:0]                held_q    [NCH];

	logic [SB-1:0] store_mem [NCH * mma_pkg::MAX_WINDOW];

	// item being worked on
	logic [mma_pkg::CHAN_BITS-1:0] item_ch_q;
	logic signed [SB-1:0]          item_s_q;
	logic [CB-1:0]                 cur_win_q;
	logic [PB-1:0]                 cur_pos_q;
	logic [CB-1:0]                 cur_held_q;
	logic signed [SUB-1:0]         cur_sum_q;
	logic [SB-1:0]                 old_q;
	logic [mma_pkg::ADDR_BITS-1:0] slot_q;

	// divider
	logic [DB-1:0]                    div_sh_q;
	logic [RB-1:0]                    div_rem_q;
	logic [CB-1:0]                    div_den_q;
	logic                             div_neg_q;
	logic [mma_pkg::DIV_CNT_BITS-1:0] div_cnt_q;

	logic rsp_valid_q;

	logic [mma_pkg::REG_BITS-1:0]  wr_raw;
	logic [CB-1:0]                 win_eff;
	logic [PB-1:0]                 pos_eff;
	logic [mma_pkg::ADDR_BITS-1:0] slot_c;

	assign cfg_rdata = win_reg_q[cfg_index];

	// effective window and ring slot of the current channel
	always_comb begin
		wr_raw = win_reg_q[item_ch_q];
		if (wr_raw == '0) begin
			win_eff = CB'(1);
		end else if (wr_raw > mma_pkg::REG_BITS'(mma_pkg::MAX_WINDOW)) begin
			win_eff = CB'(mma_pkg::MAX_WINDOW);
		end else begin
			win_eff = CB'(wr_raw);
		end
		pos_eff = ({1'b0, wpos_q[item_ch_q]} >= win_eff) ? '0 : wpos_q[item_ch_q];
		slot_c  = {item_ch_q, pos_eff};
	end

	logic                  full_c;
	logic [CB-1:0]         held_new;
	logic [CB-1:0]         pos_inc;
	logic [PB-1:0]         pos_new;
	logic signed [SUB-1:0] sub_c;
	logic signed [SUB-1:0] sum_new;
	logic [SUB-1:0]        mag_c;

	always_comb begin
		full_c   = (cur_held_q >= cur_win_q);
		held_new = full_c ? cur_held_q : cur_held_q + CB'(1);
		pos_inc  = {1'b0, cur_pos_q} + CB'(1);
		pos_new  = (pos_inc >= cur_win_q) ? '0 : pos_inc[PB-1:0];
		sub_c    = full_c ? {{(SUB-SB){old_q[SB-1]}}, old_q} : '0;
		sum_new  = cur_sum_q - sub_c + {{(SUB-SB){item_s_q[SB-1]}}, item_s_q};
		mag_c    = sum_new[SUB-1] ? (~sum_new + SUB'(1)) : sum_new;
	end

	// four restoring steps per cycle
	logic [DB-1:0] sh_c;
	logic [RB-1:0] rem_c;

	always_comb begin
		sh_c  = div_sh_q;
		rem_c = div_rem_q;
		for (int i = 0; i < mma_pkg::DIV_BITS_STEP; i++) begin
			rem_c = {rem_c[RB-2:0], sh_c[DB-1]};
			sh_c  = {sh_c[DB-2:0], 1'b0};
			if (rem_c >= {1'b0, div_den_q}) begin
				rem_c   = rem_c - {1'b0, div_den_q};
				sh_c[0] = 1'b1;
			end
		end
	end

	logic [DB-1:0] quo_signed;
	assign quo_signed = div_neg_q ? (~div_sh_q + DB'(1)) : div_sh_q;

	assign status.div_last = (div_cnt_q == mma_pkg::DIV_CNT_BITS'(mma_pkg::DIV_STEPS - 1));
	assign status.out_full = rsp_valid_q && !rsp_ready;
	assign rsp_valid       = rsp_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.read_slot) begin
			old_q <= store_mem[slot_c];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			store_mem[slot_q] <= item_s_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			item_ch_q <= req_item.channel;
			item_s_q  <= req_item.sample;
		end
		if (cmd.read_slot) begin
			cur_win_q  <= win_eff;
			cur_pos_q  <= pos_eff;
			cur_held_q <= held_q[item_ch_q];
			cur_sum_q  <= sum_q[item_ch_q];
			slot_q     <= slot_c;
		end
		if (cmd.update) begin
			div_sh_q  <= DB'(mag_c);
			div_rem_q <= '0;
			div_den_q <= held_new;
			div_neg_q <= sum_new[SUB-1];
		end else if (cmd.div_step) begin
			div_sh_q  <= sh_c;
			div_rem_q <= rem_c;
		end
		if (cmd.load_out) begin
			rsp_item.out_channel <= item_ch_q;
			rsp_item.average     <= quo_signed[SB-1:0];
			rsp_item.fill_count  <= div_den_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + mma_pkg::DIV_CNT_BITS'(1);
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				win_reg_q[i] <= mma_pkg::REG_BITS'(1);
				sum_q[i]     <= '0;
				wpos_q[i]    <= '0;
				held_q[i]    <= '0;
			end
		end else begin
			for (int i = 0; i < NCH; i++) begin
				if (cfg_write && (cfg_index == mma_pkg::CHAN_BITS'(i))) begin
					win_reg_q[i] <= cfg_value;
					sum_q[i]     <= '0;
					wpos_q[i]    <= '0;
					held_q[i]    <= '0;
				end else if (cmd.update && (item_ch_q == mma_pkg::CHAN_BITS'(i))) begin
					sum_q[i]  <= sum_new;
					wpos_q[i] <= pos_new;
					held_q[i] <= held_new;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/multichannel_moving_average_unit.sv -----
// channel   | signals                                      | moves
// req       | req_valid, req_ready, req_item               | channel and sample in
// rsp       | rsp_valid, rsp_ready, rsp_item               | channel, average, count out
// apb       | psel, penable, pwrite, paddr, pwdata, prdata | window registers
//
// an item goes through these steps from its transfer to its result in the output register:
// one store read, one update, six divider steps of four quotient bits, one load
// the six steps are those of the shared radix-16 divider
// a new item is taken the cycle after the load, while the result may still wait
// if the previous result is still held, the controller waits before loading
// reset clears the per-channel sums, positions and counts at once; the store is not cleared
`default_nettype none
module multichannel_moving_average_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             req_valid,
	output logic                                  req_ready,
	input  wire mma_pkg::in_item_t                req_item,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_ready,
	output mma_pkg::out_item_t                    rsp_item,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [mma_pkg::PADDR_BITS-1:0]   paddr,
	input  wire logic [mma_pkg::PDATA_BITS-1:0]   pwdata,
	output logic [mma_pkg::PDATA_BITS-1:0]        prdata,
	output logic                                  pready
);

	mma_pkg::cmd_t    cmd;
	mma_pkg::status_t status;

	logic                             cfg_write;
	logic [mma_pkg::CHAN_BITS-1:0]    cfg_index;
	logic [mma_pkg::REG_BITS-1:0]     cfg_rdata;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_index = paddr[mma_pkg::PADDR_BITS-1:2];
	assign prdata    = {{(mma_pkg::PDATA_BITS - mma_pkg::REG_BITS){1'b0}}, cfg_rdata};

	mma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mma_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_value (pwdata[mma_pkg::REG_BITS-1:0]),
		.cfg_rdata (cfg_rdata)
	);

endmodule
`default_nettype wire

// ----- rtl/core/mma_checker.sv -----
`default_nettype none
module mma_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_ready,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire mma_pkg::out_item_t rsp_item
);

	// a pending result holds until its transfer
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
		else $error("result dropped or changed while stalled");

	// one item at a time: busy for at least the read and update cycles
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready ##1 !req_ready)
		else $error("input taken while an item is in flight");

	// count of averaged samples is always within the window range
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_item.fill_count != '0) &&
			(rsp_item.fill_count <= mma_pkg::COUNT_BITS'(mma_pkg::MAX_WINDOW)))
		else $error("fill count out of range");

	// a result never appears in the cycle right after an input transfer
	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> !rsp_valid)
		else $error("result appeared too early");

endmodule

bind multichannel_moving_average_unit mma_checker u_chk (.*);
`default_nettype wire

// ----- verif/multichannel_moving_average_unit_tb.sv -----
`timescale 1ns / 1ps
module multichannel_moving_average_unit_tb;

	localparam int REG_WINDOW_CH0 = 0;
	localparam int TAIL_CYCLES    = 12;

	typedef enum int {SMP_WIDE, SMP_EXTREME, SMP_NEAR} sample_mix_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	mma_pkg::in_item_t req_item;
	logic rsp_valid;
	logic rsp_ready;
	mma_pkg::out_item_t rsp_item;
	logic psel;
	logic penable;
	logic pwrite;
	logic [mma_pkg::PADDR_BITS-1:0] paddr;
	logic [mma_pkg::PDATA_BITS-1:0] pwdata;
	logic [mma_pkg::PDATA_BITS-1:0] prdata;
	logic pready;

	// filter state mirrored per channel
	logic [mma_pkg::REG_BITS-1:0]           win_reg    [mma_pkg::NUM_CHANNELS];
	logic signed [mma_pkg::SUM_BITS-1:0]    chan_sum   [mma_pkg::NUM_CHANNELS];
	logic [mma_pkg::POS_BITS-1:0]           wr_pos     [mma_pkg::NUM_CHANNELS];
	logic [mma_pkg::COUNT_BITS-1:0]         held       [mma_pkg::NUM_CHANNELS];
	logic signed [mma_pkg::SAMPLE_BITS-1:0]
		ring_store [mma_pkg::NUM_CHANNELS][mma_pkg::MAX_WINDOW];

	mma_pkg::out_item_t avg_expect_q[$];
	int mismatch_count = 0;
	bit idle_on = 1'b0;
	int hold_req = 0;

	multichannel_moving_average_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #1 clk = ~clk;

	function automatic void restart_channel(int ch);
		chan_sum[ch] = '0;
		wr_pos[ch]   = '0;
		held[ch]     = '0;
	endfunction

	function automatic mma_pkg::out_item_t filter_update(mma_pkg::in_item_t it);
		int ch;
		int win;
		int slot;
		int total;
		int quot;
		logic signed [mma_pkg::SAMPLE_BITS-1:0] smp;
		mma_pkg::out_item_t r;
		ch = it.channel;
		smp = it.sample;
		win = int'(win_reg[ch]);
		if (win == 0) win = 1;
		else if (win > mma_pkg::MAX_WINDOW) win = mma_pkg::MAX_WINDOW;
		slot = int'(wr_pos[ch]);
		if (slot >= win) slot = 0;
		if (int'(held[ch]) >= win) chan_sum[ch] = chan_sum[ch] - ring_store[ch][slot];
		else held[ch] = held[ch] + 1'b1;
		ring_store[ch][slot] = smp;
		chan_sum[ch] = chan_sum[ch] + smp;
		wr_pos[ch] = (slot + 1 >= win) ? '0 : mma_pkg::POS_BITS'(slot + 1);
		total = chan_sum[ch];
		// int division truncates toward zero
		quot = total / int'(held[ch]);
		r.out_channel = it.channel;
		r.average     = quot[mma_pkg::SAMPLE_BITS-1:0];
		r.fill_count  = held[ch];
		return r;
	endfunction

	function automatic logic signed [mma_pkg::SAMPLE_BITS-1:0] pick_sample(sample_mix_t mix,
			logic signed [mma_pkg::SAMPLE_BITS-1:0] level);
		case (mix)
			SMP_EXTREME: begin
				case ($urandom_range(0, 5))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'sh8001;
					3: return -16'sd1;
					4: return 16'sd1;
					default: return 16'sd0;
				endcase
			end
			SMP_NEAR: return level ^ mma_pkg::SAMPLE_BITS'($urandom_range(0, 31));
			default: return mma_pkg::SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [mma_pkg::PDATA_BITS-1:0] pick_window_word();
		case ($urandom_range(0, 7))
			0: return 32'd1;
			1: return 32'd64;
			2: return 32'd0;
			3: return 32'($urandom_range(65, 127));
			4: return 32'($urandom_range(2, 4));
			5: return $urandom;
			default: return 32'($urandom_range(1, 64));
		endcase
	endfunction

	task automatic send_sample(logic [mma_pkg::CHAN_BITS-1:0] ch,
			logic signed [mma_pkg::SAMPLE_BITS-1:0] smp);
		mma_pkg::in_item_t it;
		it.channel = ch;
		it.sample  = smp;
		req_valid <= 1'b1;
		req_item  <= it;
		do @(posedge clk); while (!req_ready);
		avg_expect_q.push_back(filter_update(it));
	endtask

	task automatic sender_gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (avg_expect_q.size() != 0);
	endtask

	task automatic write_window(int idx, logic [mma_pkg::PDATA_BITS-1:0] word);
		logic [mma_pkg::PADDR_BITS-1:0] addr;
		addr = mma_pkg::PADDR_BITS'(4 * (REG_WINDOW_CH0 + idx));
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		win_reg[idx] = word[mma_pkg::REG_BITS-1:0];
		restart_channel(idx);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random_phase(int n_items, bit all_regs);
		int focus;
		sample_mix_t mix;
		logic signed [mma_pkg::SAMPLE_BITS-1:0] level;
		logic [mma_pkg::CHAN_BITS-1:0] ch;
		focus = $urandom_range(0, mma_pkg::NUM_CHANNELS - 1);
		mix   = sample_mix_t'($urandom_range(0, 2));
		level = mma_pkg::SAMPLE_BITS'($urandom);
		drain_results();
		for (int i = 0; i < mma_pkg::NUM_CHANNELS; i++)
			if (all_regs || $urandom_range(0, 1)) write_window(i, pick_window_word());
		for (int i = 0; i < n_items; i++) begin
			// lean on one channel so long windows fill and wrap
			ch = ($urandom_range(0, 9) < 6) ? mma_pkg::CHAN_BITS'(focus) :
				mma_pkg::CHAN_BITS'($urandom);
			if ($urandom_range(0, 15) == 0) mix = sample_mix_t'($urandom_range(0, 2));
			send_sample(ch, pick_sample(mix, level));
			sender_gap();
		end
	endtask

	task automatic test_reset_window();
		send_sample(3'd0, 16'sh7fff);
		send_sample(3'd1, 16'sh8000);
		send_sample(3'd2, 16'sd0);
		send_sample(3'd3, -16'sd1);
		send_sample(3'd4, 16'sd1);
		send_sample(3'd5, 16'sh5555);
		send_sample(3'd6, 16'shaaaa);
		send_sample(3'd7, 16'sh00ff);
	endtask

	task automatic test_window_extremes();
		drain_results();
		write_window(0, 32'd64);
		write_window(1, 32'd0);
		write_window(2, 32'd127);
		write_window(3, 32'd2);
		write_window(4, 32'd65);
		write_window(5, 32'd3);
		write_window(6, 32'hffff_ff81);
		write_window(7, 32'd64);
		send_sample(3'd3, 16'sh7fff);
		send_sample(3'd3, 16'sh7fff);
		send_sample(3'd3, 16'sh8000);
		// negative sums must round toward zero
		send_sample(3'd5, 16'sd1);
		send_sample(3'd5, -16'sd2);
		send_sample(3'd5, -16'sd2);
		send_sample(3'd5, 16'sd4);
		send_sample(3'd0, 16'sh8000);
		send_sample(3'd0, 16'sh8000);
		send_sample(3'd0, 16'sh7fff);
		send_sample(3'd1, 16'sh8000);
		send_sample(3'd2, 16'sh7fff);
		send_sample(3'd4, -16'sd1);
		send_sample(3'd6, 16'sd5);
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 5; p++) run_random_phase(130, p == 0);
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 40; i++) begin
			send_sample(mma_pkg::CHAN_BITS'($urandom), mma_pkg::SAMPLE_BITS'($urandom));
			if (i == 19) drain_results();
			else sender_gap();
		end
	endtask

	task automatic test_output_backpressure();
		drain_results();
		hold_req = 200;
		for (int i = 0; i < 30; i++)
			send_sample(mma_pkg::CHAN_BITS'($urandom), mma_pkg::SAMPLE_BITS'($urandom));
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		run_random_phase(80, 1'b1);
	endtask

	// output side stalls, plus the long hold-off on request
	initial begin : out_ready_ctl
		int n;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
				rsp_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 2) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		mma_pkg::out_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (avg_expect_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: ch %0d avg %0d count %0d",
						rsp_item.out_channel, rsp_item.average, rsp_item.fill_count);
			end else begin
				want = avg_expect_q.pop_front();
				if (rsp_item.out_channel !== want.out_channel ||
						rsp_item.average !== want.average ||
						rsp_item.fill_count !== want.fill_count) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected ch %0d avg %0d count %0d, got ch %0d avg %0d count %0d",
							want.out_channel, want.average, want.fill_count,
							rsp_item.out_channel, rsp_item.average, rsp_item.fill_count);
				end
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_item  <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		for (int ch = 0; ch < mma_pkg::NUM_CHANNELS; ch++) begin
			win_reg[ch] = 7'd1;
			restart_channel(ch);
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		test_reset_window();
		test_window_extremes();
		test_random_phases();
		test_drain_pause();
		test_output_backpressure();
		test_no_idle();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && avg_expect_q.size() == 0) begin
			$display("multichannel_moving_average_unit regression: pass");
		end else begin
			$display("multichannel_moving_average_unit regression: fail");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("multichannel_moving_average_unit regression: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/mma_pkg.sv
rtl/core/mma_ctrl.sv
rtl/core/mma_datapath.sv
rtl/core/multichannel_moving_average_unit.sv
rtl/core/mma_checker.sv
verif/multichannel_moving_average_unit_tb.sv
